>>> design/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ASCII integer parser
// Character codes, parser phase encoding and the character class bundle
// passed from the classifier to the parse engine.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned DigitWidth = 4;

    // ASCII codes the parser cares about
    localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CharWidth-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CharWidth-1:0] CHAR_LOW_F = 8'h66;
    localparam logic [CharWidth-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CharWidth-1:0] CHAR_UP_F  = 8'h46;
    localparam logic [CharWidth-1:0] CHAR_LOW_X = 8'h78;
    localparam logic [CharWidth-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_DIGIT = 1'b1;

    localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ZERO    = 3'd1,
        PH_HEXNEED = 3'd2,
        PH_HEX     = 3'd3,
        PH_SIGN    = 3'd4,
        PH_DEC     = 3'd5
    } phase_t;

    // Classification of one character
    typedef struct packed {
        logic                  is_dec;
        logic                  is_hex;
        logic                  is_zero;
        logic                  is_x;
        logic                  is_sign;
        logic                  is_minus;
        logic [DigitWidth-1:0] digit;
    } char_class_t;

endpackage

>>> design/aip_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_chan_if: request channels of the ASCII integer parser
// aip_char_if carries characters in, aip_res_if carries parsed results out.
// ----------------------------------------------------------------------------
interface aip_char_if;
    logic                               valid;
    logic                               ready;
    logic [aip_pkg::CharWidth-1:0]      ch;
    logic                               start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface aip_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [aip_pkg::ValueWidth-1:0] value;
    logic                               status;
    logic [aip_pkg::CountWidth-1:0]     used;

    modport source (output valid, output value, output status, output used, input ready);
    modport sink   (input valid, input value, input status, input used, output ready);
endinterface

>>> design/ascii_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming ASCII decimal / hex integer parser
// Input register, character classifier and parse engine with result register.
// ----------------------------------------------------------------------------
// One character is taken per cycle unless the input register is held. A
// character enters the input register, is classified and updates the
// parser state when it advances out of that register; a finished number is
// loaded into the result register as its terminating character advances.
// The terminating character is not part of the number. Throughput is one
// character per cycle while results are taken; the only stall is a full
// result register that is not being read, which holds the input register.
// Decimal accumulation is a single 64-bit shift-add per character.
module ascii_integer_parser (
    input  logic      clk,
    input  logic      rst_n,
    aip_char_if.sink  chars,
    aip_res_if.source results
);

    logic                          s1_valid_reg, s1_valid_next;
    logic [aip_pkg::CharWidth-1:0] s1_ch_reg;
    logic                          s1_start_reg;
    logic                          out_stall;
    logic                          advance;
    logic                          accept;
    aip_pkg::char_class_t          cls;

    // Handshake: the input stage moves on unless the result register is stuck
    assign out_stall   = results.valid && !results.ready;
    assign advance     = s1_valid_reg && !out_stall;
    assign chars.ready = !(s1_valid_reg && out_stall);
    assign accept      = chars.valid && chars.ready;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_valid_reg && !advance);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg    <= chars.ch;
            s1_start_reg <= chars.start_req;
        end
    end

    aip_char_class u_class (
        .ch  (s1_ch_reg),
        .cls (cls)
    );

    aip_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .start_req (s1_start_reg),
        .cls       (cls),
        .results   (results)
    );

    // A failed parse never carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == aip_pkg::STATUS_NO_DIGIT) |-> results.value == '0)
        else $error("no-digit result with non-zero value");

    // A good number consumed at least one character
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == aip_pkg::STATUS_OK) |-> results.used != '0)
        else $error("ok result with zero characters used");

    // Input stage never overwritten while held by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_stall) |-> !chars.ready)
        else $error("input accepted while input register held");

    // A held input item is still pending in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_stall) |=> s1_valid_reg && $stable(s1_ch_reg))
        else $error("held input item lost");

endmodule

>>> design/aip_char_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_char_class: character classifier
// Flags decimal and hex digits, the hex marker, signs, and gives the digit's
// numeric value (hex value for letters a-f / A-F).
// ----------------------------------------------------------------------------
module aip_char_class (
    input  logic [aip_pkg::CharWidth-1:0] ch,
    output aip_pkg::char_class_t          cls
);

    logic is_dec;
    logic is_low;
    logic is_up;

    always_comb
    begin
        is_dec = (ch >= aip_pkg::CHAR_ZERO)  && (ch <= aip_pkg::CHAR_NINE);
        is_low = (ch >= aip_pkg::CHAR_LOW_A) && (ch <= aip_pkg::CHAR_LOW_F);
        is_up  = (ch >= aip_pkg::CHAR_UP_A)  && (ch <= aip_pkg::CHAR_UP_F);

        cls.is_dec   = is_dec;
        cls.is_hex   = is_dec || is_low || is_up;
        cls.is_zero  = (ch == aip_pkg::CHAR_ZERO);
        cls.is_x     = (ch == aip_pkg::CHAR_LOW_X) || (ch == aip_pkg::CHAR_UP_X);
        cls.is_sign  = (ch == aip_pkg::CHAR_PLUS) || (ch == aip_pkg::CHAR_MINUS);
        cls.is_minus = (ch == aip_pkg::CHAR_MINUS);

        // digit value: letters map to 10..15
        if (is_dec)
        begin
            cls.digit = ch[aip_pkg::DigitWidth-1:0];
        end
        else if (is_low)
        begin
            cls.digit = aip_pkg::DigitWidth'(ch - aip_pkg::CHAR_LOW_A + 8'd10);
        end
        else if (is_up)
        begin
            cls.digit = aip_pkg::DigitWidth'(ch - aip_pkg::CHAR_UP_A + 8'd10);
        end
        else
        begin
            cls.digit = '0;
        end
    end

endmodule

>>> design/aip_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_engine: parse state machine and result register
// Holds phase, accumulator, sign and count; on each advanced character it
// updates them in one pass and loads a result into the output register when
// the number ends.
// ----------------------------------------------------------------------------
module aip_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 start_req,
    input  aip_pkg::char_class_t cls,
    aip_res_if.source            results
);

    aip_pkg::phase_t                   phase_reg, phase_next;
    logic [aip_pkg::ValueWidth-1:0]    accum_reg, accum_next;
    logic                              negative_reg, negative_next;
    logic [aip_pkg::CountWidth-1:0]    count_reg, count_next;

    logic                              out_valid_reg, out_valid_next;
    logic [aip_pkg::ValueWidth-1:0]    out_value_reg, out_value_next;
    logic                              out_status_reg, out_status_next;
    logic [aip_pkg::CountWidth-1:0]    out_used_reg, out_used_next;

    logic                              emit;
    logic [aip_pkg::ValueWidth-1:0]    emit_value;
    logic                              emit_status;
    logic [aip_pkg::CountWidth-1:0]    emit_used;
    logic [aip_pkg::CountWidth-1:0]    count_bump;
    logic [aip_pkg::ValueWidth-1:0]    digit_ext;
    logic [aip_pkg::ValueWidth-1:0]    accum_dec;
    logic [aip_pkg::ValueWidth-1:0]    accum_hex;

    // Accumulator steps: x10 as shift-add, x16 as shift
    always_comb
    begin
        digit_ext  = {{(aip_pkg::ValueWidth-aip_pkg::DigitWidth){1'b0}}, cls.digit};
        accum_dec  = (accum_reg << 3) + (accum_reg << 1) + digit_ext;
        accum_hex  = (accum_reg << 4) | digit_ext;
        count_bump = (count_reg == aip_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        negative_next = negative_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        emit_value    = '0;
        emit_status   = aip_pkg::STATUS_OK;
        emit_used     = count_reg;

        if (start_req)
        begin
            // drop any open number and begin afresh
            phase_next    = aip_pkg::PH_IDLE;
            accum_next    = '0;
            negative_next = 1'b0;
            count_next    = 8'd1;
            priority if (cls.is_zero)
            begin
                phase_next = aip_pkg::PH_ZERO;
            end
            else if (cls.is_dec)
            begin
                phase_next = aip_pkg::PH_DEC;
                accum_next = digit_ext;
            end
            else if (cls.is_sign)
            begin
                phase_next    = aip_pkg::PH_SIGN;
                negative_next = cls.is_minus;
            end
            else
            begin
                emit        = 1'b1;
                emit_status = aip_pkg::STATUS_NO_DIGIT;
                emit_used   = '0;
                count_next  = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                aip_pkg::PH_ZERO:
                begin
                    priority if (cls.is_x)
                    begin
                        phase_next = aip_pkg::PH_HEXNEED;
                        count_next = count_bump;
                    end
                    else if (cls.is_dec)
                    begin
                        phase_next = aip_pkg::PH_DEC;
                        accum_next = digit_ext;
                        count_next = count_bump;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                aip_pkg::PH_HEXNEED:
                begin
                    if (cls.is_hex)
                    begin
                        phase_next = aip_pkg::PH_HEX;
                        accum_next = digit_ext;
                        count_next = count_bump;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = aip_pkg::STATUS_NO_DIGIT;
                    end
                end
                aip_pkg::PH_HEX:
                begin
                    if (cls.is_hex)
                    begin
                        accum_next = accum_hex;
                        count_next = count_bump;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_value = accum_reg;
                    end
                end
                aip_pkg::PH_SIGN:
                begin
                    if (cls.is_dec)
                    begin
                        phase_next = aip_pkg::PH_DEC;
                        accum_next = digit_ext;
                        count_next = count_bump;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = aip_pkg::STATUS_NO_DIGIT;
                    end
                end
                aip_pkg::PH_DEC:
                begin
                    if (cls.is_dec)
                    begin
                        accum_next = accum_dec;
                        count_next = count_bump;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_value = negative_reg ? ('0 - accum_reg) : accum_reg;
                    end
                end
                default:
                begin
                    // idle: characters between numbers are ignored
                    phase_next = aip_pkg::PH_IDLE;
                end
            endcase
        end

        // ending a number clears the working state
        if (emit)
        begin
            phase_next    = aip_pkg::PH_IDLE;
            accum_next    = '0;
            negative_next = 1'b0;
            count_next    = '0;
        end
    end

    // Result register: loads on emit, clears once taken
    always_comb
    begin
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        if (advance && emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = emit_value;
            out_status_next = emit_status;
            out_used_next   = emit_used;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= aip_pkg::PH_IDLE;
            accum_reg     <= '0;
            negative_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                accum_reg    <= accum_next;
                negative_reg <= negative_next;
                count_reg    <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = out_value_reg;
    assign results.status = out_status_reg;
    assign results.used   = out_used_reg;

endmodule
